>>> design/bei_pkg.sv
// Shared types and constants of the breakpoint envelope interpolator.
`default_nettype none
package bei_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COUNT_W        = 5;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 4;
    localparam int IN_TDATA_W     = 136;
    localparam int QUO_W          = 33;
    localparam int PROD_W         = 64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        K_FALLBACK,
        K_DIRECT,
        K_INTERP
    } t_kind;

    typedef struct packed {
        logic              interp;
        logic              neg;
        logic [DATA_W-1:0] lv;
        logic [DATA_W-1:0] rv;
    } t_side;

endpackage
`default_nettype wire

>>> design/bei_ram.sv
// Generic RAM: one write port, one registered read port.
`default_nettype none
module bei_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/bei_search.sv
// Breakpoint position compare stage and segment select.
`default_nettype none
module bei_search #(
    parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_we,
    input  wire logic [AW-1:0]                     i_waddr,
    input  wire logic [bei_pkg::DATA_W-1:0]        i_wpos,
    input  wire logic                              i_qvalid,
    input  wire logic [bei_pkg::DATA_W-1:0]        i_qpos,
    input  wire logic [bei_pkg::DATA_W-1:0]        i_fb,
    input  wire logic [bei_pkg::COUNT_W-1:0]       i_count,
    output logic                                   o_valid,
    output bei_pkg::t_kind                         o_kind,
    output logic [AW-1:0]                          o_addr_l,
    output logic [AW-1:0]                          o_addr_r,
    output logic [bei_pkg::DATA_W-1:0]             o_qpos,
    output logic [bei_pkg::DATA_W-1:0]             o_fb
);

    localparam int NW = $clog2(MAX_POINTS + 1);

    logic [bei_pkg::DATA_W-1:0] r_pos [MAX_POINTS];
    logic [MAX_POINTS-1:0]      r_le;
    logic [MAX_POINTS-1:0]      r_ge;
    logic                       r_valid;
    logic [bei_pkg::DATA_W-1:0] r_qpos;
    logic [bei_pkg::DATA_W-1:0] r_fb;
    logic [NW-1:0]              n_cnt;
    logic [AW-1:0]              n_last;
    logic [AW-1:0]              n_sel;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos[i_waddr] <= i_wpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_qvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qpos <= i_qpos;
            r_fb   <= i_fb;
            for (int j = 0; j < MAX_POINTS; j++) begin
                r_le[j] <= $signed(i_qpos) <= $signed(r_pos[j]);
                r_ge[j] <= $signed(i_qpos) >= $signed(r_pos[j]);
            end
        end
    end

    always_comb begin
        if (32'(i_count) > MAX_POINTS) begin
            n_cnt = NW'(MAX_POINTS);
        end else begin
            n_cnt = NW'(i_count);
        end
        n_last = AW'(n_cnt - NW'(1));
        n_sel  = AW'(1);
        for (int j = MAX_POINTS - 1; j >= 1; j--) begin
            if ((j < 32'(n_cnt)) && r_le[j]) begin
                n_sel = AW'(j);
            end
        end
        o_addr_l = n_sel - AW'(1);
        o_addr_r = n_sel;
        o_kind   = bei_pkg::K_INTERP;
        if (n_cnt == '0) begin
            o_kind = bei_pkg::K_FALLBACK;
        end else if (r_le[0]) begin
            o_kind   = bei_pkg::K_DIRECT;
            o_addr_r = '0;
        end else if (r_ge[n_last]) begin
            o_kind   = bei_pkg::K_DIRECT;
            o_addr_r = n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_qpos  = r_qpos;
    assign o_fb    = r_fb;

endmodule
`default_nettype wire

>>> design/bei_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module bei_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [bei_pkg::PROD_W-1:0]   i_num,
    input  wire logic [bei_pkg::QUO_W-1:0]    i_den,
    input  wire bei_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [bei_pkg::QUO_W-1:0]         o_quo,
    output bei_pkg::t_side                    o_side
);

    localparam int NS = bei_pkg::QUO_W;
    localparam int TW = bei_pkg::PROD_W + 2;

    logic                          r_valid [NS];
    logic [bei_pkg::PROD_W-1:0]    r_rem   [NS];
    logic [bei_pkg::QUO_W-1:0]     r_den   [NS];
    logic [bei_pkg::QUO_W-1:0]     r_quo   [NS];
    bei_pkg::t_side                r_side  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                       p_valid;
        logic [bei_pkg::PROD_W-1:0] p_rem;
        logic [bei_pkg::QUO_W-1:0]  p_den;
        logic [bei_pkg::QUO_W-1:0]  p_quo;
        bei_pkg::t_side             p_side;
        logic [TW-1:0]              n_diff;

        if (s == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = i_num;
            assign p_den   = i_den;
            assign p_quo   = '0;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[s-1];
            assign p_rem   = r_rem[s-1];
            assign p_den   = r_den[s-1];
            assign p_quo   = r_quo[s-1];
            assign p_side  = r_side[s-1];
        end

        assign n_diff = {2'b00, p_rem} - (TW'(p_den) << (NS - 1 - s));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
                if (!n_diff[TW-1]) begin
                    r_rem[s] <= n_diff[bei_pkg::PROD_W-1:0];
                    r_quo[s] <= {p_quo[bei_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[s] <= p_rem;
                    r_quo[s] <= {p_quo[bei_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

endmodule
`default_nettype wire

>>> design/breakpoint_envelope_interpolator.sv
// Top level of the breakpoint envelope interpolator.
// Usage:
//  s_axis carries one word per item. tuser[0] selects a breakpoint write (0) or a
//  query (1). A write stores (point_position, point_level) into slot point_index
//  and yields no output; slots at or above MAX_POINTS are dropped. A query yields
//  one m_axis word with the level at query_position.
//  i_cfg_data sets the number of points in use; write it only while idle.
//  A query passes the compare stage, segment read from the point
//  RAMs, difference stage, multiply, a 33-stage divider (one quotient bit per
//  stage) and the output register. The divider sets most of the pipeline depth.
//  Throughput is one word per cycle when m_axis_tready stays high.
//  When the receiver stalls the whole pipeline freezes, s_axis_tready drops,
//  nothing is lost or repeated.
//  Reset clears the point count and all valid bits; table contents stay
//  undefined until written. o_cfg_ready is always high.
`default_nettype none
module breakpoint_envelope_interpolator #(
    parameter int MAX_POINTS = bei_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_index, point_position, point_level, query_position, fallback_level
    input  wire logic [bei_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // level_out
    output logic [bei_pkg::DATA_W-1:0]             m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bei_pkg::COUNT_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = bei_pkg::DATA_W;
    localparam int XW = DW + 1;

    logic                       en;
    logic                       acc;
    logic                       wr;
    logic [bei_pkg::IDX_W-1:0]  in_idx;
    logic [DW-1:0]              in_ppos;
    logic [DW-1:0]              in_plev;
    logic [DW-1:0]              in_qpos;
    logic [DW-1:0]              in_fb;
    logic [AW-1:0]              waddr;

    logic [bei_pkg::COUNT_W-1:0] r_count;

    logic                       s1_valid;
    bei_pkg::t_kind             s1_kind;
    logic [AW-1:0]              s1_addr_l;
    logic [AW-1:0]              s1_addr_r;
    logic [DW-1:0]              s1_qpos;
    logic [DW-1:0]              s1_fb;

    logic                       r2_valid;
    bei_pkg::t_kind             r2_kind;
    logic [DW-1:0]              r2_qpos;
    logic [DW-1:0]              r2_fb;
    logic [2*DW-1:0]            ram_l;
    logic [2*DW-1:0]            ram_r;

    logic [XW-1:0]              n3_span;
    logic [XW-1:0]              n3_off;
    logic [XW-1:0]              n3_dv;
    logic                       r3_valid;
    logic [XW-1:0]              r3_span;
    logic [XW-1:0]              r3_off;
    logic [XW-1:0]              r3_mag;
    bei_pkg::t_side             r3_side;

    logic [2*XW-1:0]            n4_prod;
    logic                       r4_valid;
    logic [bei_pkg::PROD_W-1:0] r4_prod;
    logic [XW-1:0]              r4_span;
    bei_pkg::t_side             r4_side;

    logic                       d_valid;
    logic [bei_pkg::QUO_W-1:0]  d_quo;
    bei_pkg::t_side             d_side;
    logic [XW-1:0]              n_res;

    logic                       r_out_valid;
    logic [DW-1:0]              r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && en;
    assign in_idx        = s_axis_tdata[3:0];
    assign in_ppos       = s_axis_tdata[35:4];
    assign in_plev       = s_axis_tdata[67:36];
    assign in_qpos       = s_axis_tdata[99:68];
    assign in_fb         = s_axis_tdata[131:100];
    assign wr            = acc && (s_axis_tuser[0] == bei_pkg::OP_WRITE)
                           && (32'(in_idx) < MAX_POINTS);
    assign waddr         = AW'(in_idx);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    bei_search #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_we     (wr),
        .i_waddr  (waddr),
        .i_wpos   (in_ppos),
        .i_qvalid (acc && (s_axis_tuser[0] == bei_pkg::OP_QUERY)),
        .i_qpos   (in_qpos),
        .i_fb     (in_fb),
        .i_count  (r_count),
        .o_valid  (s1_valid),
        .o_kind   (s1_kind),
        .o_addr_l (s1_addr_l),
        .o_addr_r (s1_addr_r),
        .o_qpos   (s1_qpos),
        .o_fb     (s1_fb)
    );

    bei_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_POINTS)
    ) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (waddr),
        .i_wdata ({in_plev, in_ppos}),
        .i_re    (en),
        .i_raddr (s1_addr_l),
        .o_rdata (ram_l)
    );

    bei_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_POINTS)
    ) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (wr),
        .i_waddr (waddr),
        .i_wdata ({in_plev, in_ppos}),
        .i_re    (en),
        .i_raddr (s1_addr_r),
        .o_rdata (ram_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= s1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= s1_kind;
            r2_qpos <= s1_qpos;
            r2_fb   <= s1_fb;
        end
    end

    // segment differences, sign-extended to 33 bits
    assign n3_span = {ram_r[DW-1], ram_r[DW-1:0]} - {ram_l[DW-1], ram_l[DW-1:0]};
    assign n3_off  = {r2_qpos[DW-1], r2_qpos} - {ram_l[DW-1], ram_l[DW-1:0]};
    assign n3_dv   = {ram_r[2*DW-1], ram_r[2*DW-1:DW]} - {ram_l[2*DW-1], ram_l[2*DW-1:DW]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_span        <= n3_span;
            r3_off         <= n3_off;
            r3_mag         <= n3_dv[XW-1] ? (XW'(0) - n3_dv) : n3_dv;
            r3_side.neg    <= n3_dv[XW-1];
            r3_side.lv     <= ram_l[2*DW-1:DW];
            r3_side.rv     <= (r2_kind == bei_pkg::K_FALLBACK) ? r2_fb : ram_r[2*DW-1:DW];
            r3_side.interp <= (r2_kind == bei_pkg::K_INTERP) && !n3_span[XW-1]
                              && (n3_span != '0);
        end
    end

    assign n4_prod = (2*XW)'(r3_mag) * (2*XW)'(r3_off);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_prod <= n4_prod[bei_pkg::PROD_W-1:0];
            r4_span <= r3_span;
            r4_side <= r3_side;
        end
    end

    bei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_valid),
        .i_num   (r4_prod),
        .i_den   (r4_span),
        .i_side  (r4_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    always_comb begin
        if (d_side.neg) begin
            n_res = {d_side.lv[DW-1], d_side.lv} - d_quo;
        end else begin
            n_res = {d_side.lv[DW-1], d_side.lv} + d_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= d_side.interp ? n_res[DW-1:0] : d_side.rv;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
